// File: hw/rtl/assert_macros.svh
// assertion macros shared by the divider and top-level rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define MMC_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define MMC_ASSERT(label, prop, msg) \
    `MMC_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// File: hw/rtl/mmc_pkg.sv
// shared types and constants for the magnetometer min/max calibration block
package mmc_pkg;

    localparam int FIELD_W        = 18;
    localparam int SCALE_W        = 16;
    localparam int WEIGHT_W       = 8;
    localparam int THR_W          = 16;
    localparam int LIMIT_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int DEN_W          = 20;
    localparam int SUM_W          = 20;
    localparam int RANGE_W        = 18;
    localparam int Q412_SHIFT     = 12;
    localparam int FILT_FRAC_DEF  = 6;
    localparam int DIV_NUM_W_DEF  = 32;
    localparam int AXES           = 3;
    localparam int AX_W           = 2;
    localparam int S_TDATA_W      = 56;
    localparam int M_TDATA_W      = 104;
    localparam int M_TUSER_W      = 2;

    localparam logic [AX_W-1:0]     AX_FIRST   = 2'd0;
    localparam logic [AX_W-1:0]     AX_LAST    = 2'd2;
    localparam logic [SCALE_W-1:0]  UNITY_Q412 = 16'd4096;
    localparam logic [SCALE_W-1:0]  SCALE_MAX  = 16'hFFFF;
    localparam logic [LIMIT_W-1:0]  COUNT_MAX  = 16'hFFFF;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 8'd8;
    localparam logic [THR_W-1:0]    THR_RST    = 16'd5;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIMIT     = 2'd2;

    typedef struct packed {
        logic [WEIGHT_W-1:0] filter_weight;
        logic [THR_W-1:0]    growth_threshold;
        logic [LIMIT_W-1:0]  settle_limit;
    } cfg_regs_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_NUM,
        ST_DIV,
        ST_EXT,
        ST_COUNT,
        ST_SCALE,
        ST_SDIV,
        ST_OUT
    } state_t;

endpackage

// File: hw/rtl/mmc_config.sv
// configuration register file with write channel
module mmc_config import mmc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t             cfg
);

    cfg_regs_t cfg_reg;

    assign cfg_ready = aresetn;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_weight    <= WEIGHT_RST;
            cfg_reg.growth_threshold <= THR_RST;
            cfg_reg.settle_limit     <= LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FILTER_WEIGHT: begin
                    cfg_reg.filter_weight <= cfg_data[WEIGHT_W-1:0];
                end
                CFG_GROWTH_THRESHOLD: begin
                    cfg_reg.growth_threshold <= cfg_data[THR_W-1:0];
                end
                CFG_SETTLE_LIMIT: begin
                    cfg_reg.settle_limit <= cfg_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mmc_divider.sv
// shared restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module mmc_divider import mmc_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic             rem_nz
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] denom_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   partial;
    logic [DEN_W+1:0] trial;
    logic             fits;

    assign partial  = {rem_reg, quot_reg[NUM_W-1]};
    assign trial    = {1'b0, partial} - {2'b00, denom_reg};
    assign fits     = !trial[DEN_W+1];
    assign rem_next = fits ? trial[DEN_W-1:0] : partial[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            quot_reg  <= numer;
            denom_reg <= denom;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign quot   = quot_reg;
    assign rem_nz = |rem_reg;

    `MMC_ASSERT(a_start_when_free, start |-> !busy_reg, "divider started while busy")
    `MMC_ASSERT(a_done_after_run, done_reg |-> $past(busy_reg), "divider done without a run")
    `MMC_ASSERT(a_rem_below_denom, busy_reg |-> rem_reg < denom_reg, "remainder not below divisor")

endmodule

// File: hw/rtl/magnetometer_minmax_calibration.sv
// magnetometer min/max calibration top level: sequencer and datapath
// a completing word adds up to three scale divisions on the shared divider
// words are taken one at a time, only in the idle state, as the serial divider is shared
// the next word is taken while the last result waits
// aresetn is synchronous, active low: zero state, unity scale, default registers
`include "assert_macros.svh"

module magnetometer_minmax_calibration import mmc_pkg::*; #(
    parameter int FILTER_FRAC_BITS = FILT_FRAC_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // field_x, field_y, field_z
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // start_req
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bias_x, bias_y, bias_z, scale_x, scale_y, scale_z
    output logic [M_TDATA_W-1:0]  m_tdata,
    // busy_res, done_res
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FILT_W = FIELD_W + FILTER_FRAC_BITS;
    localparam int PROD_W = FILT_W + WEIGHT_W + 1;
    localparam int MAG_W  = FILT_W + WEIGHT_W;
    localparam int DIV_NW = (MAG_W > DIV_NUM_W_DEF) ? MAG_W : DIV_NUM_W_DEF;
    localparam int DQ_W   = DIV_NW + 1;

    cfg_regs_t cfg;

    state_t state_reg;
    state_t state_next;

    logic [AX_W-1:0]           ax_reg;
    logic                      start_in_reg;
    logic signed [FIELD_W-1:0] samp_reg [AXES];
    logic signed [FILT_W-1:0]  filt_reg [AXES];
    logic signed [FIELD_W-1:0] max_reg [AXES];
    logic signed [FIELD_W-1:0] min_reg [AXES];
    logic signed [FIELD_W-1:0] bias_reg [AXES];
    logic [SCALE_W-1:0]        scale_reg [AXES];
    logic [LIMIT_W-1:0]        count_reg;
    logic                      collecting_reg;
    logic                      done_flag_reg;
    logic [FIELD_W-1:0]        growth_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic [M_TUSER_W-1:0]      m_tuser_reg;

    logic [WEIGHT_W-1:0]       k_eff;
    logic [WEIGHT_W-1:0]       k_minus1;
    logic signed [PROD_W-1:0]  num;
    logic [PROD_W-1:0]         num_mag;
    logic signed [DQ_W-1:0]    q_signed;
    logic signed [DQ_W-1:0]    q_floor;
    logic signed [FIELD_W-1:0] whole_cur;
    logic signed [FIELD_W:0]   up_diff;
    logic signed [FIELD_W:0]   down_diff;
    logic [FIELD_W-1:0]        growth_step;
    logic [LIMIT_W-1:0]        count_new;
    logic                      complete;
    logic signed [FIELD_W:0]   range_full [AXES];
    logic [RANGE_W-1:0]        range_ax [AXES];
    logic signed [FIELD_W:0]   mid_sum [AXES];
    logic [RANGE_W-1:0]        range_cur;
    logic [DEN_W-1:0]          range3;
    logic [SCALE_W-1:0]        scale_sat;
    logic                      last_ax;
    logic                      out_load;
    logic                      div_wait;

    logic                      div_start;
    logic [DIV_NW-1:0]         div_numer;
    logic [DEN_W-1:0]          div_denom;
    logic                      div_busy;
    logic                      div_done;
    logic [DIV_NW-1:0]         div_quot;
    logic                      div_rem_nz;

    mmc_config u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mmc_divider #(
        .NUM_W (DIV_NW)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot),
        .rem_nz  (div_rem_nz)
    );

    // filter arithmetic
    assign k_eff    = (cfg.filter_weight == '0) ? WEIGHT_W'(1) : cfg.filter_weight;
    assign k_minus1 = k_eff - WEIGHT_W'(1);
    assign num      = prod_reg + (PROD_W'(samp_reg[ax_reg]) <<< FILTER_FRAC_BITS);
    assign num_mag  = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    assign q_signed = $signed({1'b0, div_quot});
    assign q_floor  = neg_reg ? (-q_signed - $signed(DQ_W'(div_rem_nz))) : q_signed;

    // extreme tracking
    assign whole_cur = filt_reg[ax_reg][FILT_W-1:FILTER_FRAC_BITS];
    assign up_diff   = (FIELD_W+1)'(whole_cur) - (FIELD_W+1)'(max_reg[ax_reg]);
    assign down_diff = (FIELD_W+1)'(min_reg[ax_reg]) - (FIELD_W+1)'(whole_cur);

    always_comb begin
        growth_step = growth_reg;
        if (whole_cur > max_reg[ax_reg] && up_diff[FIELD_W-1:0] > growth_step) begin
            growth_step = up_diff[FIELD_W-1:0];
        end
        if (whole_cur < min_reg[ax_reg] && down_diff[FIELD_W-1:0] > growth_step) begin
            growth_step = down_diff[FIELD_W-1:0];
        end
    end

    // quiet counter
    always_comb begin
        if (growth_reg > FIELD_W'(cfg.growth_threshold)) begin
            count_new = '0;
        end else if (count_reg == COUNT_MAX) begin
            count_new = count_reg;
        end else begin
            count_new = count_reg + 1'b1;
        end
    end
    assign complete = count_new >= cfg.settle_limit;

    // per-axis ranges and midpoints
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            range_full[i] = (FIELD_W+1)'(max_reg[i]) - (FIELD_W+1)'(min_reg[i]);
            range_ax[i]   = range_full[i][RANGE_W-1:0];
            mid_sum[i]    = (FIELD_W+1)'(max_reg[i]) + (FIELD_W+1)'(min_reg[i]);
        end
    end

    assign range_cur = range_ax[ax_reg];
    assign range3    = DEN_W'({range_cur, 1'b0}) + DEN_W'(range_cur);
    assign scale_sat = (|div_quot[DIV_NW-1:SCALE_W]) ? SCALE_MAX : div_quot[SCALE_W-1:0];
    assign last_ax   = (ax_reg == AX_LAST);

    // divider operand select
    assign div_start = (state_reg == ST_NUM) || (state_reg == ST_SCALE && range_cur != '0);
    assign div_numer = (state_reg == ST_NUM) ? DIV_NW'(num_mag[MAG_W-1:0])
                                             : DIV_NW'({sum_reg, {Q412_SHIFT{1'b0}}});
    assign div_denom = (state_reg == ST_NUM) ? DEN_W'(k_eff) : range3;

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign div_wait = (state_reg == ST_DIV) || (state_reg == ST_SDIV);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!start_in_reg && collecting_reg) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                state_next = ST_NUM;
            end
            ST_NUM: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EXT;
                end
            end
            ST_EXT: begin
                state_next = last_ax ? ST_COUNT : ST_MUL;
            end
            ST_COUNT: begin
                state_next = complete ? ST_SCALE : ST_OUT;
            end
            ST_SCALE: begin
                if (range_cur != '0) begin
                    state_next = ST_SDIV;
                end else if (last_ax) begin
                    state_next = ST_OUT;
                end
            end
            ST_SDIV: begin
                if (div_done) begin
                    state_next = last_ax ? ST_OUT : ST_SCALE;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg         <= AX_FIRST;
            count_reg      <= '0;
            collecting_reg <= 1'b0;
            done_flag_reg  <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                filt_reg[i]  <= '0;
                max_reg[i]   <= '0;
                min_reg[i]   <= '0;
                bias_reg[i]  <= '0;
                scale_reg[i] <= UNITY_Q412;
            end
        end else begin
            case (state_reg)
                ST_DECODE: begin
                    ax_reg        <= AX_FIRST;
                    done_flag_reg <= 1'b0;
                    if (start_in_reg) begin
                        for (int i = 0; i < AXES; i++) begin
                            max_reg[i] <= samp_reg[i];
                            min_reg[i] <= samp_reg[i];
                        end
                        count_reg      <= '0;
                        collecting_reg <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        filt_reg[ax_reg] <= q_floor[FILT_W-1:0];
                    end
                end
                ST_EXT: begin
                    if (whole_cur > max_reg[ax_reg]) begin
                        max_reg[ax_reg] <= whole_cur;
                    end
                    if (whole_cur < min_reg[ax_reg]) begin
                        min_reg[ax_reg] <= whole_cur;
                    end
                    if (!last_ax) begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                ST_COUNT: begin
                    count_reg <= count_new;
                    ax_reg    <= AX_FIRST;
                    if (complete) begin
                        for (int i = 0; i < AXES; i++) begin
                            bias_reg[i] <= mid_sum[i][FIELD_W:1];
                        end
                    end
                end
                ST_SCALE: begin
                    if (range_cur == '0) begin
                        scale_reg[ax_reg] <= (sum_reg == '0) ? UNITY_Q412 : SCALE_MAX;
                        if (last_ax) begin
                            collecting_reg <= 1'b0;
                            done_flag_reg  <= 1'b1;
                        end else begin
                            ax_reg <= ax_reg + 1'b1;
                        end
                    end
                end
                ST_SDIV: begin
                    if (div_done) begin
                        scale_reg[ax_reg] <= scale_sat;
                        if (last_ax) begin
                            collecting_reg <= 1'b0;
                            done_flag_reg  <= 1'b1;
                        end else begin
                            ax_reg <= ax_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    start_in_reg <= s_tuser;
                    samp_reg[0]  <= s_tdata[FIELD_W-1:0];
                    samp_reg[1]  <= s_tdata[2*FIELD_W-1:FIELD_W];
                    samp_reg[2]  <= s_tdata[3*FIELD_W-1:2*FIELD_W];
                end
            end
            ST_DECODE: begin
                growth_reg <= '0;
            end
            ST_MUL: begin
                prod_reg <= PROD_W'(filt_reg[ax_reg]) * PROD_W'($signed({1'b0, k_minus1}));
            end
            ST_NUM: begin
                neg_reg <= num[PROD_W-1];
            end
            ST_EXT: begin
                growth_reg <= growth_step;
            end
            ST_COUNT: begin
                sum_reg <= SUM_W'(range_ax[0]) + SUM_W'(range_ax[1]) + SUM_W'(range_ax[2]);
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, scale_reg[2], scale_reg[1], scale_reg[0],
                            bias_reg[2], bias_reg[1], bias_reg[0]};
            m_tuser_reg <= {done_flag_reg, collecting_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `MMC_ASSERT(a_minmax_x, collecting_reg |-> max_reg[0] >= min_reg[0], "x max below min")
    `MMC_ASSERT(a_minmax_y, collecting_reg |-> max_reg[1] >= min_reg[1], "y max below min")
    `MMC_ASSERT(a_minmax_z, collecting_reg |-> max_reg[2] >= min_reg[2], "z max below min")
    `MMC_ASSERT(a_done_ends_run, m_tvalid && m_tuser[1] |-> !m_tuser[0], "done while busy")
    `MMC_ASSERT(a_div_in_wait, div_busy |-> div_wait, "divider running outside a wait state")
    `MMC_ASSERT(a_accept, s_tvalid && s_tready |=> state_reg == ST_DECODE, "word not decoded")

endmodule

// File: test/tb_magnetometer_minmax_calibration.sv
// testbench for magnetometer_minmax_calibration: stream words checked against a predictor
`timescale 1ns / 100ps

module tb_magnetometer_minmax_calibration import mmc_pkg::*; ();

    localparam int      FRAC         = FILT_FRAC_DEF;
    localparam int      FILT_W       = FIELD_W + FRAC;
    localparam int      RANDOM_ITEMS = 1950;
    localparam int      PHASE_ITEMS  = 165;
    localparam int      TAIL_CYCLES  = 250;
    localparam int      HOLD_CYCLES  = 3000;
    localparam longint  CYCLE_LIMIT  = 3000000;
    // unmapped register index, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                             start;
        logic [AXES-1:0][FIELD_W-1:0]     field;
    } sample_t;

    typedef struct packed {
        logic                             busy;
        logic                             done;
        logic [AXES-1:0][FIELD_W-1:0]     bias;
        logic [AXES-1:0][SCALE_W-1:0]     scale;
    } calib_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    magnetometer_minmax_calibration dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state and register copies
    logic [WEIGHT_W-1:0]        cfg_weight;
    logic [THR_W-1:0]           cfg_thresh;
    logic [LIMIT_W-1:0]         cfg_limit;
    logic signed [FILT_W-1:0]   filt_acc  [AXES];
    logic signed [FIELD_W-1:0]  ext_hi    [AXES];
    logic signed [FIELD_W-1:0]  ext_lo    [AXES];
    logic [LIMIT_W-1:0]         quiet_run;
    logic                       gathering;
    logic [FIELD_W-1:0]         out_bias  [AXES];
    logic [SCALE_W-1:0]         out_scale [AXES];

    sample_t    sample_queue[$];
    calib_out_t pending_results[$];

    int     src_idle     = 0;
    int     snk_idle     = 0;
    bit     hold_req     = 1'b0;
    int     hold_left    = 0;
    bit     word_taken   = 1'b0;
    int     mismatches   = 0;
    int     results_seen = 0;
    longint cycle_count  = 0;
    string  axis_name [AXES] = '{"x", "y", "z"};

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic calib_out_t calib_step(sample_t w);
        calib_out_t r;
        longint     s [AXES];
        longint     span [AXES];
        longint     k, whole, growth, sum, q;
        logic       finished;
        finished = 1'b0;
        for (int a = 0; a < AXES; a++)
            s[a] = longint'($signed(w.field[a]));
        if (w.start) begin
            for (int a = 0; a < AXES; a++) begin
                ext_hi[a] = FIELD_W'(s[a]);
                ext_lo[a] = FIELD_W'(s[a]);
            end
            quiet_run = '0;
            gathering = 1'b1;
        end else if (gathering) begin
            k = (cfg_weight == 0) ? 1 : longint'(cfg_weight);
            growth = 0;
            for (int a = 0; a < AXES; a++) begin
                filt_acc[a] = FILT_W'(floor_div(longint'(filt_acc[a]) * (k - 1)
                                                + (s[a] <<< FRAC), k));
                whole = floor_div(longint'(filt_acc[a]), longint'(1) << FRAC);
                if (whole > longint'(ext_hi[a])) begin
                    if (whole - longint'(ext_hi[a]) > growth)
                        growth = whole - longint'(ext_hi[a]);
                    ext_hi[a] = FIELD_W'(whole);
                end
                if (whole < longint'(ext_lo[a])) begin
                    if (longint'(ext_lo[a]) - whole > growth)
                        growth = longint'(ext_lo[a]) - whole;
                    ext_lo[a] = FIELD_W'(whole);
                end
            end
            if (growth > longint'(cfg_thresh))
                quiet_run = '0;
            else if (quiet_run != COUNT_MAX)
                quiet_run = quiet_run + 1'b1;
            if (quiet_run >= cfg_limit) begin
                sum = 0;
                for (int a = 0; a < AXES; a++) begin
                    out_bias[a] = FIELD_W'(floor_div(longint'(ext_hi[a])
                                                     + longint'(ext_lo[a]), 2));
                    span[a] = longint'(ext_hi[a]) - longint'(ext_lo[a]);
                    sum = sum + span[a];
                end
                for (int a = 0; a < AXES; a++) begin
                    if (span[a] == 0) begin
                        out_scale[a] = (sum == 0) ? UNITY_Q412 : SCALE_MAX;
                    end else begin
                        q = (sum << Q412_SHIFT) / (3 * span[a]);
                        out_scale[a] = (q > longint'(SCALE_MAX)) ? SCALE_MAX : q[SCALE_W-1:0];
                    end
                end
                gathering = 1'b0;
                finished  = 1'b1;
            end
        end
        r.busy = gathering;
        r.done = finished;
        for (int a = 0; a < AXES; a++) begin
            r.bias[a]  = out_bias[a];
            r.scale[a] = out_scale[a];
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
    endtask

    function automatic void queue_sample(logic start, int x, int y, int z);
        sample_t w;
        w.start    = start;
        w.field[0] = x[FIELD_W-1:0];
        w.field[1] = y[FIELD_W-1:0];
        w.field[2] = z[FIELD_W-1:0];
        sample_queue.push_back(w);
    endfunction

    function automatic int jitter(int spread);
        return int'($urandom_range(2 * spread)) - spread;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FILTER_WEIGHT:    cfg_weight = val[WEIGHT_W-1:0];
            CFG_GROWTH_THRESHOLD: cfg_thresh = val[THR_W-1:0];
            CFG_SETTLE_LIMIT:     cfg_limit  = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // input driver
    always @(negedge aclk) begin : feed
        sample_t w;
        if (aresetn && (!s_tvalid || word_taken)) begin
            if (sample_queue.size() != 0 && int'($urandom_range(99)) >= src_idle) begin
                w = sample_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'(w.field);
                s_tuser  <= w.start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and the long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (int'($urandom_range(99)) >= snk_idle);
            end
        end
    end

    // monitor: predict on accepted words, check accepted results
    always @(posedge aclk) begin : watch
        calib_out_t got, want;
        if (aresetn) begin
            word_taken = s_tvalid && s_tready;
            if (word_taken)
                pending_results.push_back(
                    calib_step(sample_t'({s_tuser, s_tdata[AXES*FIELD_W-1:0]})));
            if (m_tvalid && m_tready) begin
                got.busy  = m_tuser[0];
                got.done  = m_tuser[1];
                got.bias  = m_tdata[AXES*FIELD_W-1:0];
                got.scale = m_tdata[AXES*FIELD_W +: AXES*SCALE_W];
                if (pending_results.size() == 0) begin
                    flag_mismatch("result word with nothing pending", 0, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.busy !== want.busy)
                        flag_mismatch("busy_res", got.busy, want.busy);
                    if (got.done !== want.done)
                        flag_mismatch("done_res", got.done, want.done);
                    for (int a = 0; a < AXES; a++) begin
                        if (got.bias[a] !== want.bias[a])
                            flag_mismatch({"bias_", axis_name[a]}, $signed(got.bias[a]),
                                          $signed(want.bias[a]));
                        if (got.scale[a] !== want.scale[a])
                            flag_mismatch({"scale_", axis_name[a]}, got.scale[a], want.scale[a]);
                    end
                end
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int phase, random_count, phase_end, len, spread, cx, cy, cz;
        cfg_weight = WEIGHT_RST;
        cfg_thresh = THR_RST;
        cfg_limit  = LIMIT_RST;
        quiet_run  = '0;
        gathering  = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            filt_acc[a]  = '0;
            ext_hi[a]    = '0;
            ext_lo[a]    = '0;
            out_bias[a]  = '0;
            out_scale[a] = UNITY_Q412;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset register values
        queue_sample(0, 0, -131072, 131071);
        queue_sample(1, 100, -200, 300);
        queue_sample(0, 131071, -131072, 5);
        queue_sample(0, -131072, 131071, -5);
        queue_sample(0, 0, 0, 0);
        wait_drained();

        // pass-through filter, zero threshold, single quiet word
        write_reg(CFG_FILTER_WEIGHT, 16'd1);
        write_reg(CFG_GROWTH_THRESHOLD, 16'd0);
        write_reg(CFG_SETTLE_LIMIT, 16'd1);
        write_reg(CFG_SPARE, 16'hA5C3);
        queue_sample(1, 1000, -1000, 7);
        queue_sample(0, 1000, -1000, 7);
        queue_sample(1, -3, 10, 131071);
        queue_sample(0, -4, 10, 131071);
        queue_sample(0, -4, 10, 131071);
        queue_sample(1, -131072, -131072, -131072);
        queue_sample(0, 131071, 131071, 131071);
        queue_sample(0, 131071, 131071, 131071);
        queue_sample(0, 5, 6, 7);
        wait_drained();

        // weight zero, settle limit zero, maximum threshold
        write_reg(CFG_FILTER_WEIGHT, 16'hFF00);
        write_reg(CFG_GROWTH_THRESHOLD, 16'hFFFF);
        write_reg(CFG_SETTLE_LIMIT, 16'd0);
        queue_sample(1, 5, 5, 5);
        queue_sample(0, -7, 9, 0);
        queue_sample(0, 3, 3, 3);
        wait_drained();

        // slowest filter and restart while collecting
        write_reg(CFG_FILTER_WEIGHT, 16'd255);
        write_reg(CFG_SETTLE_LIMIT, 16'd3);
        queue_sample(1, 0, 0, 0);
        queue_sample(0, 131071, -131072, 1);
        queue_sample(1, -50, 60, -70);
        queue_sample(0, 131071, -131072, 1);
        queue_sample(0, 131071, -131072, 1);
        queue_sample(0, -131072, 131071, -1);
        wait_drained();

        random_count = 0;
        for (phase = 0; random_count < RANDOM_ITEMS; phase++) begin
            case (phase)
                0:       write_reg(CFG_FILTER_WEIGHT, {8'($urandom), 8'd1});
                1:       write_reg(CFG_FILTER_WEIGHT, 16'd255);
                2:       write_reg(CFG_FILTER_WEIGHT, 16'd0);
                default: write_reg(CFG_FILTER_WEIGHT, {8'($urandom), 8'($urandom_range(1, 255))});
            endcase
            case (phase)
                1:       write_reg(CFG_GROWTH_THRESHOLD, 16'd0);
                4:       write_reg(CFG_GROWTH_THRESHOLD, 16'hFFFF);
                default: write_reg(CFG_GROWTH_THRESHOLD, (phase % 3 == 0) ?
                                   16'($urandom_range(0, 3)) : 16'($urandom_range(4, 400)));
            endcase
            case (phase)
                2:       write_reg(CFG_SETTLE_LIMIT, 16'd0);
                3:       write_reg(CFG_SETTLE_LIMIT, 16'd1);
                6:       write_reg(CFG_SETTLE_LIMIT, 16'hFFFF);
                default: write_reg(CFG_SETTLE_LIMIT, 16'($urandom_range(1, 40)));
            endcase
            case (phase % 4)
                0: begin src_idle = 0;  snk_idle = 0;  end
                1: begin src_idle = 46; snk_idle = 0;  end
                2: begin src_idle = 0;  snk_idle = 46; end
                default: begin src_idle = 11; snk_idle = 11; end
            endcase
            if (phase == 0)
                hold_req = 1'b1;
            phase_end = random_count + PHASE_ITEMS;
            while (random_count < phase_end) begin
                if ($urandom_range(99) < 85) begin
                    cx = int'($urandom_range(240000)) - 120000;
                    cy = int'($urandom_range(240000)) - 120000;
                    cz = int'($urandom_range(240000)) - 120000;
                    spread = ($urandom_range(4) == 0) ? int'($urandom_range(1, 10000))
                                                      : int'($urandom_range(0, 300));
                    len = $urandom_range(2, 40);
                    queue_sample(1, cx + jitter(spread), cy + jitter(spread), cz + jitter(spread));
                    for (int i = 0; i < len; i++)
                        queue_sample(0, cx + jitter(spread), cy + jitter(spread),
                                     cz + jitter(spread));
                    random_count += len + 1;
                end else begin
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++)
                        queue_sample($urandom_range(3) == 0, int'($urandom), int'($urandom),
                                     int'($urandom));
                    random_count += len;
                end
            end
            wait_drained();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mmc_pkg.sv
hw/rtl/mmc_config.sv
hw/rtl/mmc_divider.sv
hw/rtl/magnetometer_minmax_calibration.sv
test/tb_magnetometer_minmax_calibration.sv
